>>> design/cfwl_pkg.sv
// shared constants, codes, state and divider interface types for the caption
// fade window lookup unit; no dependencies
package cfwl_pkg;

   localparam int MAX_SEGMENTS = 1024;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = IDX_BITS + 1;
   localparam int TIME_BITS    = 32;
   localparam int TRANS_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 16;
   localparam int Q_BITS       = 17;
   localparam int POS_BITS     = TIME_BITS + 4;
   localparam int DEN_BITS     = TRANS_BITS + 2;
   localparam int DIV_BITS     = DEN_BITS + 16;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
   localparam int P1_BITS      = 2 * Q_BITS;
   localparam int W_BITS       = Q_BITS + 1;
   localparam int P2_BITS      = P1_BITS + W_BITS;

   localparam logic [Q_BITS-1:0] Q_ONE       = Q_BITS'(65536);
   localparam logic [Q_BITS-1:0] ALPHA_FLOOR = Q_BITS'(131);
   localparam logic [W_BITS-1:0] THREE_Q     = W_BITS'(3 * 65536);

   localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_SEGMENTS);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_TRANSITION = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SEG_COUNT  = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BS_ISSUE,
      ST_BS_CHK,
      ST_SC_ISSUE,
      ST_SC_CHK,
      ST_NB_CHK,
      ST_RAMP,
      ST_DIV,
      ST_SM1,
      ST_SM2,
      ST_SM3,
      ST_EVAL,
      ST_HIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DEN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

>>> design/cfwl_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module cfwl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/cfwl_div.sv
// restoring divider, one quotient bit per cycle, for the ramp position
// depends on cfwl_pkg
module cfwl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cfwl_pkg::div_req_type req,
   output cfwl_pkg::div_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cfwl_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [cfwl_pkg::DEN_BITS-1:0]     rem_ff, rem_in;
   logic [cfwl_pkg::DEN_BITS-1:0]     den_ff, den_in;
   logic [cfwl_pkg::DIV_BITS-1:0]     quo_ff, quo_in;
   logic [cfwl_pkg::DEN_BITS:0]       rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, quo_ff[cfwl_pkg::DIV_BITS-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = cfwl_pkg::DEN_BITS'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[cfwl_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[cfwl_pkg::DEN_BITS-1:0];
            quo_in = {quo_ff[cfwl_pkg::DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cfwl_pkg::DIV_CNT_BITS'(cfwl_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> design/caption_fade_window_lookup_unit.sv
// caption fade window lookup: segment tables in two rams, binary search,
// forward scan, smoothstep fade alpha per candidate
// depends on cfwl_pkg, cfwl_ram, cfwl_div
// a load item gives no result. a query runs binary search steps, then scans
// segments forward, each with a hard cut or with a fade whose two ramps may
// each wait on the shared divider, then a step per hit and one to finish;
// one item at a time.
// reset clears control state and registers; table entries stay undefined
// until loaded, with no clearing pass.
module caption_fade_window_lookup_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [cfwl_pkg::IDX_BITS-1:0]        req_load_index,
   input  logic [cfwl_pkg::TIME_BITS-1:0]       req_seg_start_ms,
   input  logic [cfwl_pkg::TIME_BITS-1:0]       req_seg_end_ms,
   input  logic [cfwl_pkg::TIME_BITS-1:0]       req_query_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cfwl_pkg::IDX_BITS-1:0]        rsp_active_index,
   output logic [cfwl_pkg::Q_BITS-1:0]          rsp_alpha,
   output logic                                 rsp_found,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cfwl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cfwl_pkg::CSR_DAT_BITS-1:0]    csr_wdata
);

   localparam int IB = cfwl_pkg::IDX_BITS;
   localparam int CB = cfwl_pkg::CNT_BITS;
   localparam int TB = cfwl_pkg::TIME_BITS;
   localparam int PB = cfwl_pkg::POS_BITS;
   localparam int QB = cfwl_pkg::Q_BITS;
   localparam int DB = cfwl_pkg::DEN_BITS;

   cfwl_pkg::state_type state_ff, state_in;

   logic [cfwl_pkg::TRANS_BITS-1:0] trans_ff;
   logic [CB-1:0]                   seg_count_ff;

   logic [TB-1:0]          ms_ff, ms_in;
   logic [CB-1:0]          cnt_ff, cnt_in;
   logic signed [CB:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [IB-1:0]          mid_ff, mid_in;
   logic [CB-1:0]          first_ff, first_in;
   logic [CB-1:0]          idx_ff, idx_in;
   logic [1:0]             hits_ff, hits_in;
   logic [TB-1:0]          seg_s_ff, seg_s_in, seg_e_ff, seg_e_in;
   logic signed [PB-1:0]   num_in_ff, num_in_in, num_out_ff, num_out_in;
   logic [DB-1:0]          den_in_ff, den_in_in, den_out_ff, den_out_in;
   logic                   phase_ff, phase_in;
   logic [QB-1:0]          x_ff, x_in;
   logic [cfwl_pkg::P1_BITS-1:0] p1_ff, p1_in;
   logic [cfwl_pkg::W_BITS-1:0]  w_ff, w_in;
   logic [cfwl_pkg::P2_BITS-1:0] p2_ff, p2_in;
   logic [QB-1:0]          a_in_ff, a_in_in, alpha_ff, alpha_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IB-1:0]          pend_idx_ff, pend_idx_in;
   logic [QB-1:0]          pend_alpha_ff, pend_alpha_in;

   logic                   rsp_valid_ff;
   logic [IB-1:0]          rsp_idx_ff;
   logic [QB-1:0]          rsp_alpha_ff;
   logic                   rsp_found_ff, rsp_last_ff;
   logic                   rsp_load;
   logic [IB-1:0]          rsp_idx_in;
   logic [QB-1:0]          rsp_alpha_in;
   logic                   rsp_found_in, rsp_last_in;

   logic                   req_accept, out_free, load_we;
   logic [IB-1:0]          start_raddr, end_raddr;
   logic [TB-1:0]          start_rd, end_rd;

   cfwl_pkg::div_req_type  div_req;
   cfwl_pkg::div_rsp_type  div_rsp;

   logic [TB-1:0]          half;
   logic [CB:0]            mid_sum;
   logic signed [PB-1:0]   m2, s2, e2, t2, in_lo, in_hi, out_lo, out_hi;
   logic signed [PB-1:0]   d_in, d_out, gap_b, gap_a, num_sel;
   logic [DB-1:0]          den_sel;
   logic                   room_b, room_a;
   logic [cfwl_pkg::P2_BITS-1:0] p2_rnd;
   logic [QB-1:0]          s_val;

   assign half       = TB'(trans_ff >> 1);
   assign req_stall  = (state_ff != cfwl_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_we    = req_accept && (req_op == cfwl_pkg::OP_LOAD);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   cfwl_ram #(.WIDTH(TB), .DEPTH(cfwl_pkg::MAX_SEGMENTS)) u_start_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (req_load_index),
      .wdata (req_seg_start_ms),
      .raddr (start_raddr),
      .rdata (start_rd)
   );

   cfwl_ram #(.WIDTH(TB), .DEPTH(cfwl_pkg::MAX_SEGMENTS)) u_end_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (req_load_index),
      .wdata (req_seg_end_ms),
      .raddr (end_raddr),
      .rdata (end_rd)
   );

   cfwl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // read addresses: neighbours of the candidate are read in the check state
   always_comb begin
      start_raddr = idx_ff[IB-1:0];
      end_raddr   = idx_ff[IB-1:0];
      if (state_ff == cfwl_pkg::ST_BS_ISSUE) begin
         end_raddr = mid_sum[IB:1];
      end else if (state_ff == cfwl_pkg::ST_SC_CHK) begin
         start_raddr = IB'(idx_ff + 1'b1);
         end_raddr   = IB'(idx_ff - 1'b1);
      end
   end

   // positions in half-millisecond units
   always_comb begin
      mid_sum = CB'(lo_ff) + CB'(hi_ff);
      m2      = $signed({3'b000, ms_ff, 1'b0});
      s2      = $signed({3'b000, seg_s_ff, 1'b0});
      e2      = $signed({3'b000, seg_e_ff, 1'b0});
      t2      = $signed(PB'(trans_ff));
      gap_b   = $signed(PB'(seg_s_ff)) - $signed(PB'(end_rd));
      gap_a   = $signed(PB'(start_rd)) - $signed(PB'(seg_e_ff));
      room_b  = (idx_ff == '0) || (gap_b >= $signed(PB'(half)));
      room_a  = ((idx_ff + 1'b1) >= cnt_ff) || (gap_a >= $signed(PB'(half)));
      in_lo   = room_b ? s2 - t2 : s2;
      in_hi   = s2 + t2;
      out_lo  = e2 - t2;
      out_hi  = room_a ? e2 + t2 : e2;
      d_in    = in_hi - in_lo;
      d_out   = out_hi - out_lo;
      if (d_in < $signed(PB'(2))) begin
         d_in = $signed(PB'(2));
      end
      if (d_out < $signed(PB'(2))) begin
         d_out = $signed(PB'(2));
      end
      num_sel = phase_ff ? num_out_ff : num_in_ff;
      den_sel = phase_ff ? den_out_ff : den_in_ff;
      p2_rnd  = p2_ff + cfwl_pkg::P2_BITS'(64'h8000_0000);
      s_val   = p2_rnd[32 +: QB];
   end

   always_comb begin
      state_in      = state_ff;
      ms_in         = ms_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      first_in      = first_ff;
      idx_in        = idx_ff;
      hits_in       = hits_ff;
      seg_s_in      = seg_s_ff;
      seg_e_in      = seg_e_ff;
      num_in_in     = num_in_ff;
      num_out_in    = num_out_ff;
      den_in_in     = den_in_ff;
      den_out_in    = den_out_ff;
      phase_in      = phase_ff;
      x_in          = x_ff;
      p1_in         = p1_ff;
      w_in          = w_ff;
      p2_in         = p2_ff;
      a_in_in       = a_in_ff;
      alpha_in      = alpha_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_alpha_in = pend_alpha_ff;
      rsp_load      = 1'b0;
      rsp_idx_in    = pend_idx_ff;
      rsp_alpha_in  = pend_alpha_ff;
      rsp_found_in  = 1'b1;
      rsp_last_in   = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {num_sel[DB-1:0], 16'h0000} + cfwl_pkg::DIV_BITS'(den_sel >> 1);
      div_req.divisor  = den_sel;

      unique case (state_ff)
         cfwl_pkg::ST_IDLE: begin
            if (req_accept && (req_op == cfwl_pkg::OP_QUERY)) begin
               ms_in         = req_query_ms;
               cnt_in        = (seg_count_ff > cfwl_pkg::MAX_COUNT) ?
                               cfwl_pkg::MAX_COUNT : seg_count_ff;
               lo_in         = '0;
               hi_in         = $signed({1'b0, cnt_in}) - $signed((CB + 1)'(1));
               first_in      = cnt_in;
               hits_in       = '0;
               pend_valid_in = 1'b0;
               state_in      = cfwl_pkg::ST_BS_ISSUE;
            end
         end
         cfwl_pkg::ST_BS_ISSUE: begin
            if (lo_ff <= hi_ff) begin
               mid_in   = mid_sum[IB:1];
               state_in = cfwl_pkg::ST_BS_CHK;
            end else begin
               idx_in   = first_ff;
               state_in = cfwl_pkg::ST_SC_ISSUE;
            end
         end
         cfwl_pkg::ST_BS_CHK: begin
            if (({1'b0, end_rd} + {1'b0, half}) > {1'b0, ms_ff}) begin
               first_in = CB'(mid_ff);
               hi_in    = $signed({2'b00, mid_ff}) - $signed((CB + 1)'(1));
            end else begin
               lo_in    = $signed({2'b00, mid_ff}) + $signed((CB + 1)'(1));
            end
            state_in = cfwl_pkg::ST_BS_ISSUE;
         end
         cfwl_pkg::ST_SC_ISSUE: begin
            if ((idx_ff < cnt_ff) && (hits_ff < 2'd2)) begin
               state_in = cfwl_pkg::ST_SC_CHK;
            end else begin
               state_in = cfwl_pkg::ST_FINISH;
            end
         end
         cfwl_pkg::ST_SC_CHK: begin
            seg_s_in = start_rd;
            seg_e_in = end_rd;
            if ({1'b0, start_rd} > ({1'b0, ms_ff} + {1'b0, half})) begin
               state_in = cfwl_pkg::ST_FINISH;
            end else if (trans_ff == '0) begin
               // hard cut
               alpha_in = ((ms_ff >= start_rd) && (ms_ff < end_rd)) ? cfwl_pkg::Q_ONE : '0;
               state_in = cfwl_pkg::ST_EVAL;
            end else begin
               state_in = cfwl_pkg::ST_NB_CHK;
            end
         end
         cfwl_pkg::ST_NB_CHK: begin
            num_in_in  = m2 - in_lo;
            num_out_in = out_hi - m2;
            den_in_in  = d_in[DB-1:0];
            den_out_in = d_out[DB-1:0];
            phase_in   = 1'b0;
            state_in   = cfwl_pkg::ST_RAMP;
         end
         cfwl_pkg::ST_RAMP: begin
            if (num_sel <= $signed(PB'(0))) begin
               x_in     = '0;
               state_in = cfwl_pkg::ST_SM1;
            end else if (num_sel >= $signed(PB'(den_sel))) begin
               x_in     = cfwl_pkg::Q_ONE;
               state_in = cfwl_pkg::ST_SM1;
            end else begin
               div_req.start = 1'b1;
               state_in      = cfwl_pkg::ST_DIV;
            end
         end
         cfwl_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               x_in     = {1'b0, div_rsp.quotient[15:0]};
               state_in = cfwl_pkg::ST_SM1;
            end
         end
         cfwl_pkg::ST_SM1: begin
            p1_in    = x_ff * x_ff;
            w_in     = cfwl_pkg::THREE_Q - {x_ff, 1'b0};
            state_in = cfwl_pkg::ST_SM2;
         end
         cfwl_pkg::ST_SM2: begin
            p2_in    = p1_ff * w_ff;
            state_in = cfwl_pkg::ST_SM3;
         end
         cfwl_pkg::ST_SM3: begin
            if (!phase_ff) begin
               a_in_in  = s_val;
               phase_in = 1'b1;
               state_in = cfwl_pkg::ST_RAMP;
            end else begin
               alpha_in = (a_in_ff < s_val) ? a_in_ff : s_val;
               state_in = cfwl_pkg::ST_EVAL;
            end
         end
         cfwl_pkg::ST_EVAL: begin
            if (alpha_ff > cfwl_pkg::ALPHA_FLOOR) begin
               state_in = cfwl_pkg::ST_HIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = cfwl_pkg::ST_SC_ISSUE;
            end
         end
         cfwl_pkg::ST_HIT: begin
            // the held hit goes out only once a later one shows it is not last
            if (!pend_valid_ff || out_free) begin
               rsp_load      = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_idx_in   = idx_ff[IB-1:0];
               pend_alpha_in = alpha_ff;
               hits_in       = hits_ff + 1'b1;
               idx_in        = idx_ff + 1'b1;
               state_in      = cfwl_pkg::ST_SC_ISSUE;
            end
         end
         cfwl_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_found_in  = pend_valid_ff;
               if (!pend_valid_ff) begin
                  rsp_idx_in   = '0;
                  rsp_alpha_in = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = cfwl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfwl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cfwl_pkg::ST_IDLE;
         trans_ff      <= '0;
         seg_count_ff  <= '0;
         hits_ff       <= '0;
         pend_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hits_ff       <= hits_in;
         pend_valid_ff <= pend_valid_in;
         phase_ff      <= phase_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cfwl_pkg::REG_TRANSITION: trans_ff     <= csr_wdata[cfwl_pkg::TRANS_BITS-1:0];
               cfwl_pkg::REG_SEG_COUNT:  seg_count_ff <= csr_wdata[CB-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      ms_ff         <= ms_in;
      cnt_ff        <= cnt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      first_ff      <= first_in;
      idx_ff        <= idx_in;
      seg_s_ff      <= seg_s_in;
      seg_e_ff      <= seg_e_in;
      num_in_ff     <= num_in_in;
      num_out_ff    <= num_out_in;
      den_in_ff     <= den_in_in;
      den_out_ff    <= den_out_in;
      x_ff          <= x_in;
      p1_ff         <= p1_in;
      w_ff          <= w_in;
      p2_ff         <= p2_in;
      a_in_ff       <= a_in_in;
      alpha_ff      <= alpha_in;
      pend_idx_ff   <= pend_idx_in;
      pend_alpha_ff <= pend_alpha_in;
      if (rsp_load) begin
         rsp_idx_ff   <= rsp_idx_in;
         rsp_alpha_ff <= rsp_alpha_in;
         rsp_found_ff <= rsp_found_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_active_index = rsp_idx_ff;
   assign rsp_alpha        = rsp_alpha_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_last         = rsp_last_ff;

   a_not_found_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_last && (rsp_alpha == '0)))
      else $error("not-found item must be last with zero alpha");

   a_found_above_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_alpha > cfwl_pkg::ALPHA_FLOOR))
      else $error("found item with alpha at or below floor");

   a_hits_bounded: assert property (@(posedge clock) disable iff (reset)
      (hits_ff <= 2'd2) && (!pend_valid_ff || (hits_ff != 2'd0)))
      else $error("hit count out of range");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == cfwl_pkg::ST_DIV))
      else $error("divider finished outside its wait state");

endmodule
